/* hdl/dpms_pkg.sv */
// dpms_pkg: shared constants and types for the dimuon pair mass selector
// no dependencies
package dpms_pkg;

  localparam int ETA_BITS      = 14;
  localparam int ETA_ABS_BITS  = 13;
  localparam int ETA_ABS_RESET = 5120;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = 3;
  localparam int FIFO_CW       = FIFO_AW + 1;

  typedef enum logic [1:0] {
    REG_MIN_PT      = 2'd0,
    REG_MAX_ABS_ETA = 2'd1,
    REG_MASS_LOW    = 2'd2,
    REG_MASS_HIGH   = 2'd3
  } reg_idx_t;

endpackage

/* hdl/dpms_in_if.sv */
// dpms_in_if: muon input channel, valid/ready with one muon per transfer
// depends on dpms_pkg
interface dpms_in_if #(
  parameter int MOMENTUM_BITS = 20
);
  logic                                valid;
  logic                                ready;
  logic                                last_in_event;
  logic                                is_tracker;
  logic                                is_global;
  logic [MOMENTUM_BITS-1:0]            global_pt;
  logic signed [dpms_pkg::ETA_BITS-1:0] global_eta;
  logic [MOMENTUM_BITS-1:0]            inner_pt;
  logic signed [dpms_pkg::ETA_BITS-1:0] inner_eta;
  logic [MOMENTUM_BITS-1:0]            energy;
  logic signed [MOMENTUM_BITS:0]       mom_x;
  logic signed [MOMENTUM_BITS:0]       mom_y;
  logic signed [MOMENTUM_BITS:0]       mom_z;
  logic                                charge_negative;

  modport source (
    output valid, last_in_event, is_tracker, is_global, global_pt, global_eta,
           inner_pt, inner_eta, energy, mom_x, mom_y, mom_z, charge_negative,
    input  ready
  );

  modport sink (
    input  valid, last_in_event, is_tracker, is_global, global_pt, global_eta,
           inner_pt, inner_eta, energy, mom_x, mom_y, mom_z, charge_negative,
    output ready
  );
endinterface

/* hdl/dpms_out_if.sv */
// dpms_out_if: event result channel, valid/ready with one result per transfer
// no dependencies
interface dpms_out_if #(
  parameter int MOMENTUM_BITS = 20
);
  logic                             valid;
  logic                             ready;
  logic                             accept;
  logic [2*(MOMENTUM_BITS+1)-1:0]   mass_squared;

  modport source (
    output valid, accept, mass_squared,
    input  ready
  );

  modport sink (
    input  valid, accept, mass_squared,
    output ready
  );
endinterface

/* hdl/dimuon_pair_mass_selector_unit.sv */
// dimuon_pair_mass_selector_unit: per-event dimuon selection with squared mass window
// depends on dpms_pkg, dpms_in_if, dpms_out_if
// a result is valid once the event's last muon has passed pipe stages 1 to 4 into the fifo
// throughput: one muon per cycle; four-stage arithmetic pipe feeds an 8-entry result fifo
// input stalls only when 8 results are pending in pipe and fifo
// reset: synchronous active-low rst_n clears event state, pipe valids and fifo pointers
module dimuon_pair_mass_selector_unit #(
  parameter int MOMENTUM_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dpms_in_if.sink                             in_ch,
  dpms_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpms_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dpms_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dpms_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  localparam int PTW  = MOMENTUM_BITS;
  localparam int MOMW = MOMENTUM_BITS + 1;
  localparam int SW   = MOMENTUM_BITS + 2;
  localparam int MSQW = 2 * MOMW;
  localparam int SQW  = 2 * SW;
  localparam int EW   = dpms_pkg::ETA_BITS;
  localparam int AEW  = dpms_pkg::ETA_ABS_BITS;
  localparam int DW   = dpms_pkg::CFG_DATA_BITS;
  localparam int FAW  = dpms_pkg::FIFO_AW;
  localparam int FCW  = dpms_pkg::FIFO_CW;

  // configuration registers
  logic [PTW-1:0]  min_pt_r;
  logic [AEW-1:0]  max_abs_eta_r;
  logic [MOMW-1:0] mass_low_r;
  logic [MOMW-1:0] mass_high_r;
  logic [MSQW-1:0] lo2_r;
  logic [MSQW-1:0] hi2_r;
  logic            cfg_we;
  dpms_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = dpms_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pt_r      <= '0;
      max_abs_eta_r <= AEW'(dpms_pkg::ETA_ABS_RESET);
      mass_low_r    <= '0;
      mass_high_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dpms_pkg::REG_MIN_PT:      min_pt_r      <= pwdata[PTW-1:0];
        dpms_pkg::REG_MAX_ABS_ETA: max_abs_eta_r <= pwdata[AEW-1:0];
        dpms_pkg::REG_MASS_LOW:    mass_low_r    <= pwdata[MOMW-1:0];
        dpms_pkg::REG_MASS_HIGH:   mass_high_r   <= pwdata[MOMW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dpms_pkg::REG_MIN_PT:      prdata = DW'(min_pt_r);
      dpms_pkg::REG_MAX_ABS_ETA: prdata = DW'(max_abs_eta_r);
      dpms_pkg::REG_MASS_LOW:    prdata = DW'(mass_low_r);
      dpms_pkg::REG_MASS_HIGH:   prdata = DW'(mass_high_r);
      default:                   prdata = '0;
    endcase
  end

  // squared window bounds
  always_ff @(posedge clk) begin
    lo2_r <= mass_low_r * mass_low_r;
    hi2_r <= mass_high_r * mass_high_r;
  end

  // muon cuts and event state
  logic [1:0]      muon_count_r, muon_count_nxt;
  logic            event_rejected_r, event_rejected_nxt;
  logic [PTW-1:0]  first_energy_r;
  logic [MOMW-1:0] first_mom_x_r, first_mom_y_r, first_mom_z_r;
  logic            first_charge_negative_r;
  logic            first_tracker_only_r;

  logic            in_xfer;
  logic [PTW-1:0]  pt_sel;
  logic [EW-1:0]   eta_sel;
  logic [EW-1:0]   abs_eta;
  logic            tracker_only;
  logic            muon_pass;
  logic            rej_now;
  logic            eval_now;
  logic [1:0]      count_inc;

  assign in_xfer      = in_ch.valid & in_ch.ready;
  assign pt_sel       = in_ch.is_tracker ? in_ch.inner_pt : in_ch.global_pt;
  assign eta_sel      = in_ch.is_tracker ? in_ch.inner_eta : in_ch.global_eta;
  assign abs_eta      = eta_sel[EW-1] ? EW'(~eta_sel + 1'b1) : eta_sel;
  assign tracker_only = in_ch.is_tracker & ~in_ch.is_global;
  assign muon_pass    = (in_ch.is_tracker | in_ch.is_global)
                        && (pt_sel >= min_pt_r)
                        && (abs_eta <= {1'b0, max_abs_eta_r});
  assign rej_now      = event_rejected_r | ~muon_pass;
  assign eval_now     = in_ch.last_in_event && (muon_count_r == 2'd1) && !rej_now;
  assign count_inc    = (muon_count_r == 2'd3) ? 2'd3 : muon_count_r + 2'd1;

  always_comb begin
    muon_count_nxt     = muon_count_r;
    event_rejected_nxt = event_rejected_r;
    if (in_xfer) begin
      if (in_ch.last_in_event) begin
        muon_count_nxt     = '0;
        event_rejected_nxt = 1'b0;
      end else begin
        muon_count_nxt     = count_inc;
        event_rejected_nxt = rej_now | (count_inc >= 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muon_count_r            <= '0;
      event_rejected_r        <= 1'b0;
      first_energy_r          <= '0;
      first_mom_x_r           <= '0;
      first_mom_y_r           <= '0;
      first_mom_z_r           <= '0;
      first_charge_negative_r <= 1'b0;
      first_tracker_only_r    <= 1'b0;
    end else begin
      muon_count_r     <= muon_count_nxt;
      event_rejected_r <= event_rejected_nxt;
      if (in_xfer && muon_count_r == 2'd0) begin
        first_energy_r          <= in_ch.energy;
        first_mom_x_r           <= in_ch.mom_x;
        first_mom_y_r           <= in_ch.mom_y;
        first_mom_z_r           <= in_ch.mom_z;
        first_charge_negative_r <= in_ch.charge_negative;
        first_tracker_only_r    <= tracker_only;
      end
    end
  end

  // pair sums
  logic [MOMW-1:0] e_sum;
  logic [SW-1:0]   x_sum, y_sum, z_sum;

  assign e_sum = {1'b0, first_energy_r} + {1'b0, in_ch.energy};
  assign x_sum = {first_mom_x_r[MOMW-1], first_mom_x_r} + {in_ch.mom_x[MOMW-1], in_ch.mom_x};
  assign y_sum = {first_mom_y_r[MOMW-1], first_mom_y_r} + {in_ch.mom_y[MOMW-1], in_ch.mom_y};
  assign z_sum = {first_mom_z_r[MOMW-1], first_mom_z_r} + {in_ch.mom_z[MOMW-1], in_ch.mom_z};

  // stage 1: sums and pair flags
  logic            s1_valid_r, s1_eval_r, s1_ok_r;
  logic [MOMW-1:0] s1_e_r;
  logic [SW-1:0]   s1_x_r, s1_y_r, s1_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer & in_ch.last_in_event;
    end
  end

  always_ff @(posedge clk) begin
    s1_eval_r <= eval_now;
    s1_ok_r   <= eval_now && (first_charge_negative_r == in_ch.charge_negative)
                 && !(first_tracker_only_r && tracker_only);
    s1_e_r    <= e_sum;
    s1_x_r    <= x_sum[SW-1] ? SW'(~x_sum + 1'b1) : x_sum;
    s1_y_r    <= y_sum[SW-1] ? SW'(~y_sum + 1'b1) : y_sum;
    s1_z_r    <= z_sum[SW-1] ? SW'(~z_sum + 1'b1) : z_sum;
  end

  // stage 2: squares
  logic            s2_valid_r, s2_eval_r, s2_ok_r;
  logic [MSQW-1:0] s2_e2_r;
  logic [SQW-1:0]  s2_x2_r, s2_y2_r, s2_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_eval_r <= s1_eval_r;
    s2_ok_r   <= s1_ok_r;
    s2_e2_r   <= s1_e_r * s1_e_r;
    s2_x2_r   <= s1_x_r * s1_x_r;
    s2_y2_r   <= s1_y_r * s1_y_r;
    s2_z2_r   <= s1_z_r * s1_z_r;
  end

  // stage 3: momentum squared
  logic            s3_valid_r, s3_eval_r, s3_ok_r;
  logic [MSQW-1:0] s3_e2_r;
  logic [SQW-1:0]  s3_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_eval_r <= s2_eval_r;
    s3_ok_r   <= s2_ok_r;
    s3_e2_r   <= s2_e2_r;
    s3_p2_r   <= s2_x2_r + s2_y2_r + s2_z2_r;
  end

  // stage 4: mass squared, clamped at zero
  logic            s4_valid_r, s4_ok_r;
  logic [MSQW-1:0] s4_msq_r;
  logic [SQW-1:0]  e2_ext;

  assign e2_ext = SQW'(s3_e2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_ok_r  <= s3_ok_r;
    s4_msq_r <= (s3_eval_r && s3_p2_r < e2_ext) ? MSQW'(e2_ext - s3_p2_r) : '0;
  end

  // window check and result fifo
  logic            win_accept;
  logic            fifo_acc_r [dpms_pkg::FIFO_DEPTH];
  logic [MSQW-1:0] fifo_msq_r [dpms_pkg::FIFO_DEPTH];
  logic [FAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]  fifo_cnt_r, fifo_cnt_nxt;
  logic [FCW-1:0]  pend_r, pend_nxt;
  logic            out_xfer;
  logic            pend_add;

  assign win_accept = s4_ok_r && (s4_msq_r >= lo2_r) && (s4_msq_r <= hi2_r);
  assign out_xfer   = out_ch.valid & out_ch.ready;
  assign pend_add   = in_xfer & in_ch.last_in_event;

  always_ff @(posedge clk) begin
    if (s4_valid_r) begin
      fifo_acc_r[wr_ptr_r] <= win_accept;
      fifo_msq_r[wr_ptr_r] <= s4_msq_r;
    end
  end

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (s4_valid_r && !out_xfer) begin
      fifo_cnt_nxt = fifo_cnt_r + 1'b1;
    end else if (!s4_valid_r && out_xfer) begin
      fifo_cnt_nxt = fifo_cnt_r - 1'b1;
    end
    pend_nxt = pend_r;
    if (pend_add && !out_xfer) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!pend_add && out_xfer) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (s4_valid_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  assign in_ch.ready         = (pend_r != FCW'(dpms_pkg::FIFO_DEPTH));
  assign out_ch.valid        = (fifo_cnt_r != '0);
  assign out_ch.accept       = fifo_acc_r[rd_ptr_r];
  assign out_ch.mass_squared = fifo_msq_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r <= FCW'(dpms_pkg::FIFO_DEPTH)) && (fifo_cnt_r <= pend_r))
    else $error("pending result count out of range");

  a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_in_event) |=> s1_valid_r)
    else $error("last muon did not enter the pipe");

  a_accept_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accept) |->
      (out_ch.mass_squared >= lo2_r && out_ch.mass_squared <= hi2_r))
    else $error("accepted event outside mass window");

  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_in_event) |=>
      (muon_count_r == 2'd0 && !event_rejected_r))
    else $error("event state not cleared after last muon");
`endif

endmodule
